// ----- rtl/brq_pkg.sv -----
// ----------------------------------------------------------------------------
// brq_pkg: shared types and constants for the bounded request queue
// Entry layout, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package brq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W  = 32;
  localparam int LEN_W = 40;
  localparam int TS_W  = 48;
  localparam int OCC_W = 5;
  localparam int ENTRY_W = ID_W + LEN_W + 2 * TS_W;

  localparam logic       OP_ENQ     = 1'b0;
  localparam logic       OP_DEQ     = 1'b1;
  localparam logic       POL_FIFO   = 1'b0;
  localparam logic       POL_SJN    = 1'b1;
  localparam logic [0:0] REG_POLICY = 1'b0;
  localparam logic [0:0] REG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] len;
    logic [TS_W-1:0]  sent;
    logic [TS_W-1:0]  rcpt;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DEQ,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/brq_ram.sv -----
// ----------------------------------------------------------------------------
// brq_ram: generic single-port-write, single-port-read RAM
// Registered read.
// ----------------------------------------------------------------------------
module brq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/bounded_request_queue_fifo_sjn_top.sv -----
// ----------------------------------------------------------------------------
// bounded_request_queue_fifo_sjn_top: bounded request queue, FIFO or SJN
//
// Usage: pulse start with in_op and the request fields while busy is low.
// An enqueue (op 0) is refused with out_rejected when occupancy has reached
// min(queue_limit, depth). Otherwise it goes to the tail (FIFO policy) or
// in front of the first stored entry whose length is not smaller (SJN).
// A dequeue (op 1) returns the head, or out_empty_res when none is stored.
// One result per request, shown for a single cycle on out_valid; the
// receiver cannot stall, so nothing waits on it.
// Entries live in one RAM, head at address 0; inserts and removals move
// entries one at a time through the RAM's single read and write port.
// An SJN enqueue scans to the insert point, then shifts. busy covers it
// all; the next request can be taken in the cycle the result is shown.
// Config: cfg_valid/cfg_ready, cfg_index 0 policy, 1 queue_limit; taken
// while idle. Reset: count 0, FIFO, limit 16; RAM contents need no clear.
// ----------------------------------------------------------------------------
module bounded_request_queue_fifo_sjn_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [brq_pkg::ID_W-1:0]   in_req_id,
  input  logic [brq_pkg::LEN_W-1:0]  in_req_length,
  input  logic [brq_pkg::TS_W-1:0]   in_sent_time,
  input  logic [brq_pkg::TS_W-1:0]   in_receipt_time,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [brq_pkg::OCC_W-1:0]  cfg_data,
  output logic                       out_valid,
  output logic                       out_rejected,
  output logic                       out_empty_res,
  output logic [brq_pkg::ID_W-1:0]   out_id,
  output logic [brq_pkg::LEN_W-1:0]  out_length,
  output logic [brq_pkg::TS_W-1:0]   out_sent_time,
  output logic [brq_pkg::TS_W-1:0]   out_receipt_time,
  output logic [brq_pkg::OCC_W-1:0]  out_occupancy
);
  import brq_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic               policy_r;
  logic [OCC_W-1:0]   limit_r;
  entry_t             req_r, req_nxt;
  logic               rej_r, rej_nxt, emp_r, emp_nxt, ov_r, ov_nxt;
  entry_t             res_r, res_nxt;
  logic               rd_pend_r, rd_pend_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  entry_t             wr_data, rd_data;
  logic [CNT_W-1:0]   eff_limit;

  brq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign eff_limit = (OCC_W'(limit_r) > OCC_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
                                                              : CNT_W'(limit_r);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE) && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      policy_r  <= POL_FIFO;
      limit_r   <= OCC_W'(16);
      ov_r      <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ov_r      <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POLICY) policy_r <= cfg_data[0];
        else                         limit_r  <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    pos_r <= pos_nxt;
    req_r <= req_nxt;
    rej_r <= rej_nxt;
    emp_r <= emp_nxt;
    res_r <= res_nxt;
  end

  // Read issued in a cycle, data used in the next (rd_pend_r marks it).
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    pos_nxt     = pos_r;
    req_nxt     = req_r;
    rej_nxt     = rej_r;
    emp_nxt     = emp_r;
    res_nxt     = res_r;
    ov_nxt      = 1'b0;
    rd_pend_nxt = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = ptr_r[IDX_W-1:0];
    wr_data     = req_r;
    rd_addr     = ptr_r[IDX_W-1:0];
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = '{id: in_req_id, len: in_req_length,
                      sent: in_sent_time, rcpt: in_receipt_time};
          rej_nxt = 1'b0;
          emp_nxt = 1'b0;
          res_nxt = '0;
          ptr_nxt = '0;
          if (in_op == OP_ENQ) begin
            if (count_r >= eff_limit) begin
              rej_nxt   = 1'b1;
              state_nxt = ST_DONE;
            end else if (policy_r == POL_SJN && count_r != '0) begin
              rd_addr     = '0;
              rd_pend_nxt = 1'b1;
              state_nxt   = ST_SCAN;
            end else begin
              pos_nxt   = count_r;
              ptr_nxt   = count_r;
              state_nxt = ST_SHIFT;
            end
          end else begin
            if (count_r == '0) begin
              emp_nxt   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              pos_nxt     = '0;
              rd_addr     = '0;
              rd_pend_nxt = 1'b1;
              state_nxt   = ST_DEQ;
            end
          end
        end
      end
      ST_SCAN: begin
        // rd_data holds entry ptr_r
        if (rd_data.len >= req_r.len) begin
          pos_nxt   = ptr_r;
          ptr_nxt   = count_r;
          state_nxt = ST_SHIFT;
        end else if (ptr_r + CNT_W'(1) == count_r) begin
          pos_nxt   = count_r;
          ptr_nxt   = count_r;
          state_nxt = ST_SHIFT;
        end else begin
          ptr_nxt     = ptr_r + CNT_W'(1);
          rd_addr     = IDX_W'(ptr_r + CNT_W'(1));
          rd_pend_nxt = 1'b1;
        end
      end
      ST_SHIFT: begin
        // ptr_r walks down from count to pos; each step copies ptr-1 to ptr
        if (ptr_r == pos_r) begin
          wr_en     = 1'b1;
          wr_data   = req_r;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = ST_DONE;
        end else if (!rd_pend_r) begin
          rd_addr     = IDX_W'(ptr_r - CNT_W'(1));
          rd_pend_nxt = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          ptr_nxt = ptr_r - CNT_W'(1);
        end
      end
      ST_DEQ: begin
        // pos_r differs from count_r until the head is captured;
        // after that rd_data is entry ptr+1, stored at ptr
        if (pos_r != count_r) begin
          res_nxt = rd_data;
          pos_nxt = count_r;
          if (count_r == CNT_W'(1)) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = ST_DONE;
          end else begin
            rd_addr     = IDX_W'(ptr_r + CNT_W'(1));
            rd_pend_nxt = 1'b1;
          end
        end else begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          ptr_nxt = ptr_r + CNT_W'(1);
          if (ptr_r + CNT_W'(2) == count_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = ST_DONE;
          end else begin
            rd_addr     = IDX_W'(ptr_r + CNT_W'(2));
            rd_pend_nxt = 1'b1;
          end
        end
      end
      ST_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid        = ov_r;
  assign out_rejected     = rej_r;
  assign out_empty_res    = emp_r;
  assign out_id           = res_r.id;
  assign out_length       = res_r.len;
  assign out_sent_time    = res_r.sent;
  assign out_receipt_time = res_r.rcpt;
  assign out_occupancy    = OCC_W'(count_r);

endmodule
